FILE: design/cba_pkg.sv
// Shared types and codes for the contiguous block allocator.
package cba_pkg;

  // Request kinds
  typedef enum logic {
    ActAlloc = 1'b0,
    ActRead  = 1'b1
  } cba_action_e;

  // Response status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StPastEnd  = 2'd1,
    StOccupied = 2'd2,
    StFull     = 2'd3
  } cba_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SRdWait,
    SScan,
    SMark,
    SResp
  } cba_state_e;

  // Request payload
  typedef struct packed {
    cba_action_e action;
    logic [6:0]  start_block;
    logic [7:0]  run_length;
  } cba_req_t;

  // Response payload
  typedef struct packed {
    cba_status_e status;
    logic [4:0]  owner;
    logic [6:0]  conflict_block;
  } cba_rsp_t;

endpackage

FILE: design/cba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/contiguous_block_allocator_unit.sv
// Contiguous block allocator: block ownership map in a RAM plus a file counter.
//
// After reset the block sweeps the map to zero, one entry per cycle, with
// req_ready_o low. A read request answers with the owner of its start block,
// or past end beyond the map. An allocate request that is rejected as full or
// past end answers without touching the map; otherwise one pass reads the run
// through the RAM read port, one block per cycle (stopping early on a
// conflict), and a second pass writes the file number through the RAM write
// port. One request is in service at a time; the response is held in a
// register until taken.
module contiguous_block_allocator_unit
  import cba_pkg::*;
#(
  parameter int NUM_BLOCKS = 128,
  parameter int MAX_FILES  = 31
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  cba_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output cba_rsp_t rsp_o
);

  localparam int AW  = $clog2(NUM_BLOCKS);
  localparam int NBW = $clog2(NUM_BLOCKS + 1);
  localparam int CW  = (NBW > 9) ? NBW : 9;
  localparam int FW  = $clog2(MAX_FILES + 1);

  cba_state_e      state_q, state_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   beg_q, beg_d;
  logic [CW-1:0]   end_q, end_d;
  logic            chk_vld_q, chk_vld_d;
  logic [CW-1:0]   chk_addr_q, chk_addr_d;
  logic [FW-1:0]   cnt_q, cnt_d;
  cba_rsp_t        rsp_q, rsp_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [FW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [FW-1:0]   ram_rdata;

  logic [CW-1:0]   start_ext;
  logic [CW-1:0]   run_end;
  logic [FW-1:0]   file_no;
  logic [FW+4:0]   file_wide;
  logic [FW+4:0]   rd_wide;

  // Ownership map
  cba_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request arithmetic
  assign start_ext = CW'(req_i.start_block);
  assign run_end   = start_ext + CW'(req_i.run_length);
  assign file_no   = cnt_q + FW'(1);
  assign file_wide = {5'b0, file_no};
  assign rd_wide   = {5'b0, ram_rdata};

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      ptr_q     <= '0;
      chk_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      chk_vld_q <= chk_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    beg_q      <= beg_d;
    end_q      <= end_d;
    chk_addr_q <= chk_addr_d;
    rsp_q      <= rsp_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    beg_d       = beg_q;
    end_d       = end_q;
    chk_vld_d   = 1'b0;
    chk_addr_d  = chk_addr_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[AW-1:0];
    ram_wdata   = '0;
    ram_raddr   = ptr_q[AW-1:0];
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    unique case (state_q)
      SClear: begin
        ram_we = 1'b1;
        if (ptr_q == CW'(NUM_BLOCKS - 1)) begin
          ptr_d   = '0;
          state_d = SIdle;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end

      SIdle: begin
        req_ready_o = 1'b1;
        ram_raddr   = start_ext[AW-1:0];
        rsp_d.owner          = '0;
        rsp_d.conflict_block = '0;
        if (req_valid_i) begin
          if (req_i.action == ActRead) begin
            if (start_ext >= CW'(NUM_BLOCKS)) begin
              rsp_d.status = StPastEnd;
              state_d      = SResp;
            end else begin
              state_d = SRdWait;
            end
          end else if (cnt_q == FW'(MAX_FILES)) begin
            rsp_d.status = StFull;
            state_d      = SResp;
          end else if (run_end > CW'(NUM_BLOCKS)) begin
            rsp_d.status = StPastEnd;
            state_d      = SResp;
          end else begin
            ptr_d   = start_ext;
            beg_d   = start_ext;
            end_d   = run_end;
            state_d = SScan;
          end
        end
      end

      SRdWait: begin
        rsp_d.status         = StOk;
        rsp_d.owner          = rd_wide[4:0];
        rsp_d.conflict_block = '0;
        state_d              = SResp;
      end

      // Read one block per cycle, check the data in the cycle after
      SScan: begin
        if (chk_vld_q && (ram_rdata != '0)) begin
          rsp_d.status         = StOccupied;
          rsp_d.owner          = '0;
          rsp_d.conflict_block = chk_addr_q[6:0];
          state_d              = SResp;
        end else if (ptr_q != end_q) begin
          chk_vld_d  = 1'b1;
          chk_addr_d = ptr_q;
          ptr_d      = ptr_q + CW'(1);
        end else if (!chk_vld_q) begin
          ptr_d   = beg_q;
          state_d = SMark;
        end
      end

      // Write the new file number over the run
      SMark: begin
        if (ptr_q != end_q) begin
          ram_we    = 1'b1;
          ram_wdata = file_no;
          ptr_d     = ptr_q + CW'(1);
        end else begin
          cnt_d                = file_no;
          rsp_d.status         = StOk;
          rsp_d.owner          = file_wide[4:0];
          rsp_d.conflict_block = '0;
          state_d              = SResp;
        end
      end

      SResp: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  // Never take a request while a response is pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken while response pending");

  // File counter stays within the file number range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FW'(MAX_FILES))
    else $error("file counter out of range");

  // Marking writes only inside the map
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMark && ram_we) |-> (ptr_q < CW'(NUM_BLOCKS)))
    else $error("mark write past end of map");

  // Only a successful allocate advances the counter, by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == SMark
                                 && cnt_q == $past(cnt_q) + FW'(1)))
    else $error("file counter moved outside a successful allocate");

  // Rejected requests report no owner
  a_reject_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != StOk) |-> (rsp_o.owner == '0))
    else $error("rejected request reports an owner");
`endif

endmodule

FILE: sim/contiguous_block_allocator_unit_tb.sv
// Self-checking testbench for the contiguous block allocator: directed and random traffic, predicted responses.
module contiguous_block_allocator_unit_tb;
  import cba_pkg::*;

  localparam int NumBlocks     = 128;
  localparam int MaxFiles      = 31;
  localparam int RandomItems   = 1000;
  localparam int QuietItems    = 150;
  localparam int DrainCycles   = 300;
  localparam int TimeoutCycles = 1_500_000;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  cba_req_t req_data  = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  cba_rsp_t rsp_data;

  // Predicted allocator state
  logic [4:0]  owner_map [NumBlocks];
  int unsigned files_issued;

  cba_req_t    req_items [$];
  cba_rsp_t    pending_responses [$];
  int unsigned sent_count     = 0;
  int unsigned accepted_count = 0;
  int          failures       = 0;
  bit          quiet          = 1'b0;
  int          gap_left       = 0;
  int          stall_left     = 0;
  longint      cycle_count    = 0;

  always #5 clk_i = ~clk_i;

  contiguous_block_allocator_unit #(
    .NUM_BLOCKS(NumBlocks),
    .MAX_FILES (MaxFiles)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req_data),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp_data)
  );

  // Expected response for one request; updates the predicted map and file count
  function automatic cba_rsp_t allocator_predict(cba_req_t r);
    cba_rsp_t    rsp;
    int unsigned first;
    int unsigned last;
    rsp        = '0;
    rsp.status = StOk;
    first      = r.start_block;
    last       = first + r.run_length;
    // a read beyond the map reports past end
    if (r.action == ActRead) begin
      if (first >= NumBlocks) begin
        rsp.status = StPastEnd;
      end else begin
        rsp.owner = owner_map[first];
      end
      return rsp;
    end
    if (files_issued >= MaxFiles) begin
      rsp.status = StFull;
      return rsp;
    end
    if (last > NumBlocks) begin
      rsp.status = StPastEnd;
      return rsp;
    end
    for (int unsigned j = first; j < last; j++) begin
      if (owner_map[j] != '0) begin
        rsp.status         = StOccupied;
        rsp.conflict_block = 7'(j);
        return rsp;
      end
    end
    files_issued++;
    for (int unsigned j = first; j < last; j++) owner_map[j] = 5'(files_issued);
    rsp.owner = 5'(files_issued);
    return rsp;
  endfunction

  task automatic push_request(cba_action_e act, int unsigned start, int unsigned len);
    cba_req_t r;
    r.action      = act;
    r.start_block = 7'(start);
    r.run_length  = 8'(len);
    req_items.push_back(r);
  endtask

  // Random request: reads, fitting runs, runs past the end, runs aimed at owned blocks
  task automatic push_random_item();
    cba_req_t    r;
    int unsigned pick;
    int unsigned s;
    int unsigned o;
    int unsigned k;
    int unsigned len;
    bit          found;
    pick          = $urandom_range(0, 99);
    r.action      = ActAlloc;
    r.start_block = 7'($urandom_range(0, NumBlocks - 1));
    r.run_length  = 8'($urandom_range(0, 255));
    s             = r.start_block;
    found         = 1'b0;
    if (pick < 35) begin
      r.action = ActRead;
    end else if (pick < 43) begin
      len          = (NumBlocks - s < 6) ? NumBlocks - s : 6;
      r.run_length = 8'($urandom_range(0, len));
    end else begin
      if (pick >= 70) begin
        // look for an owned block from a random point and straddle it
        k = $urandom_range(0, NumBlocks - 1);
        for (int i = 0; i < NumBlocks && !found; i++) begin
          o = (k + i) % NumBlocks;
          if (owner_map[o] != '0) found = 1'b1;
        end
      end
      if (found) begin
        s   = o - $urandom_range(0, (o < 8) ? o : 8);
        len = o - s + $urandom_range(1, 8);
        if (s + len > NumBlocks) len = NumBlocks - s;
        r.start_block = 7'(s);
        r.run_length  = 8'(len);
      end else begin
        r.run_length = 8'($urandom_range(NumBlocks - s + 1, 255));
      end
    end
    req_items.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_items.size() != 0 || sent_count != accepted_count ||
           pending_responses.size() != 0) @(posedge clk_i);
  endtask

  // Request driver: new request only once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_valid || sent_count == accepted_count) begin
        if (gap_left > 0) begin
          req_valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (req_items.size() > 0) begin
          req_data   <= req_items.pop_front();
          req_valid  <= 1'b1;
          sent_count <= sent_count + 1;
          if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 16);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side back-pressure in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 16);
    end
  end

  // Monitor: check taken responses, predict accepted requests
  always @(posedge clk_i) begin
    cba_rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_responses.size() == 0) begin
          $error("response %p with no request outstanding", rsp_data);
          failures++;
        end else begin
          exp_rsp = pending_responses.pop_front();
          if (rsp_data.status !== exp_rsp.status) begin
            $error("field status expected %0d actual %0d", exp_rsp.status, rsp_data.status);
            failures++;
          end
          if (rsp_data.owner !== exp_rsp.owner) begin
            $error("field owner expected %0d actual %0d", exp_rsp.owner, rsp_data.owner);
            failures++;
          end
          if (rsp_data.conflict_block !== exp_rsp.conflict_block) begin
            $error("field conflict_block expected %0d actual %0d",
                   exp_rsp.conflict_block, rsp_data.conflict_block);
            failures++;
          end
        end
      end
      if (req_valid && req_ready) begin
        pending_responses.push_back(allocator_predict(req_data));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TimeoutCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumBlocks; i++) owner_map[i] = '0;
    files_issued = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads at both ends, zero length, edge runs, conflicts
    push_request(ActRead, 0, 255);
    push_request(ActRead, 127, 0);
    push_request(ActAlloc, 0, 0);
    push_request(ActAlloc, 127, 1);
    push_request(ActAlloc, 127, 2);
    push_request(ActAlloc, 0, 255);
    push_request(ActAlloc, 1, 128);
    push_request(ActAlloc, 0, 128);
    push_request(ActAlloc, 10, 20);
    push_request(ActAlloc, 5, 10);
    push_request(ActAlloc, 29, 1);
    push_request(ActAlloc, 30, 0);
    push_request(ActRead, 10, 128);
    push_request(ActRead, 29, 1);
    push_request(ActRead, 30, 0);
    push_request(ActRead, 127, 0);
    push_request(ActAlloc, 126, 2);
    push_request(ActAlloc, 126, 1);

    // hold the sender until every response is back
    wait_drained();

    // Random phase; the file numbers run out along the way
    for (int n = 0; n < RandomItems; n++) begin
      while (req_items.size() >= 2) @(posedge clk_i);
      if (RandomItems - n == QuietItems) quiet = 1'b1;
      push_random_item();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
